FILE: rtl/core/dmn_pkg.sv
// ----------------------------------------------------------------------------
// dmn_pkg: shared types and constants for the division magic number block
// Field widths, step counts and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dmn_pkg;

    localparam int DivW     = 31;   // divisor field
    localparam int MagicW   = 32;   // magic multiplier field
    localparam int ShiftW   = 5;    // post-multiply shift field
    localparam int QuotBits = 32;   // quotient bits produced by the divider
    localparam int CntW     = $clog2(QuotBits);
    localparam int GrpBits  = 8;    // bits per group in the bit-length encoder
    localparam int GrpNum   = (DivW + GrpBits - 1) / GrpBits;
    localparam int GrpLenW  = $clog2(GrpBits + 1);

    typedef struct packed {
        logic load;     // capture the divisor word
        logic enc;      // first encoder pass: per-group bit lengths
        logic setup;    // second encoder pass: shift and starting remainder
        logic step;     // one restoring divide step
        logic finish;   // move result into the output register
    } dmn_cmd_t;

    typedef struct packed {
        logic last_step;
    } dmn_sts_t;

endpackage

FILE: rtl/core/dmn_req_if.sv
// ----------------------------------------------------------------------------
// dmn_req_if: divisor channel
// Valid/ready channel that carries one divisor word.
// ----------------------------------------------------------------------------
interface dmn_req_if
    import dmn_pkg::*;
();

    logic            valid;
    logic            ready;
    logic [DivW-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);

endinterface

FILE: rtl/core/dmn_rsp_if.sv
// ----------------------------------------------------------------------------
// dmn_rsp_if: result channel
// Valid/ready channel that carries one magic multiplier and shift word.
// ----------------------------------------------------------------------------
interface dmn_rsp_if
    import dmn_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic signed [MagicW-1:0] magic;
    logic        [ShiftW-1:0] shift;

    modport source (output valid, output magic, output shift, input ready);
    modport sink   (input valid, input magic, input shift, output ready);

endinterface

FILE: rtl/core/dmn_dp.sv
// ----------------------------------------------------------------------------
// dmn_dp: datapath
// Two-pass bit-length encoder, radix-2 restoring divider for the low
// quotient bits of 2^(31+l)/d, and the result output register.
// ----------------------------------------------------------------------------
module dmn_dp
    import dmn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dmn_cmd_t                 cmd,
    output dmn_sts_t                 sts,
    input  logic        [DivW-1:0]   divisor,
    output logic signed [MagicW-1:0] magic,
    output logic        [ShiftW-1:0] shift
);

    logic        [DivW-1:0]    div_reg;
    logic                      zero_reg;
    logic        [GrpLenW-1:0] grp_len_reg [GrpNum];
    logic        [GrpLenW-1:0] grp_len_next [GrpNum];
    logic        [ShiftW-1:0]  shift_reg;
    logic        [ShiftW-1:0]  shift_next;
    logic        [DivW-1:0]    rem_reg;
    logic        [DivW-1:0]    rem_next;
    logic        [DivW-1:0]    rem_init;
    logic        [QuotBits-1:0] quot_reg;
    logic        [CntW-1:0]    cnt_reg;
    logic signed [MagicW-1:0]  magic_reg;
    logic        [ShiftW-1:0]  shift_out_reg;

    logic [GrpNum*GrpBits-1:0] dm1;
    logic [ShiftW-1:0]         l_raw;
    logic [DivW:0]             twice;
    logic [DivW+1:0]           diff;
    logic                      qbit;

    // bit length of d-1, first pass: per group
    always_comb
    begin
        dm1 = (GrpNum*GrpBits)'(div_reg - DivW'(1));
        for (int g = 0; g < GrpNum; g++)
        begin
            grp_len_next[g] = '0;
            for (int i = 0; i < GrpBits; i++)
            begin
                if (dm1[g*GrpBits + i])
                    grp_len_next[g] = GrpLenW'(i + 1);
            end
        end
    end

    // second pass: pick the highest nonzero group
    always_comb
    begin
        l_raw = '0;
        for (int g = 0; g < GrpNum; g++)
        begin
            if (grp_len_reg[g] != '0)
                l_raw = ShiftW'(g * GrpBits) + ShiftW'(grp_len_reg[g]);
        end
        // l is raised to 1; 2^(31+l) / 2^32 leaves 2^(l-1) mod d as the start
        if (l_raw == '0)
        begin
            shift_next = '0;
            rem_init   = '0;
        end
        else
        begin
            shift_next = l_raw - ShiftW'(1);
            rem_init   = DivW'(1) << shift_next;
        end
    end

    // restoring step: remainder stays below d, so 2r fits 32 bits
    always_comb
    begin
        twice = {rem_reg, 1'b0};
        diff  = {1'b0, twice} - {2'b00, div_reg};
        qbit  = ~diff[DivW+1];
        rem_next = qbit ? diff[DivW-1:0] : twice[DivW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        if (cmd.enc)
            grp_len_reg <= grp_len_next;
        if (cmd.setup)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_init;
            quot_reg  <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QuotBits-2:0], qbit};
        end
        if (cmd.finish)
        begin
            magic_reg     <= zero_reg ? '0 : MagicW'(quot_reg + QuotBits'(1));
            shift_out_reg <= zero_reg ? '0 : shift_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.setup)
            cnt_reg <= '0;
        else if (cmd.step)
            cnt_reg <= cnt_reg + CntW'(1);
    end

    assign sts.last_step = (cnt_reg == CntW'(QuotBits - 1));
    assign magic         = magic_reg;
    assign shift         = shift_out_reg;

endmodule

FILE: rtl/core/dmn_ctrl.sv
// ----------------------------------------------------------------------------
// dmn_ctrl: controller
// Sequences one word through encode, divide and output, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module dmn_ctrl
    import dmn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dmn_sts_t sts,
    output dmn_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ENC  = 5'b00010,
        ST_SET  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ENC;
                end
            end
            ST_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = ST_SET;
            end
            ST_SET:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.last_step)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/division_magic_number.sv
// ----------------------------------------------------------------------------
// division_magic_number: magic multiplier and shift for invariant division
// For a divisor d returns magic = low 32 bits of 1 + 2^(31+l)/d and
// shift = l-1, with l = max(1, ceil(log2 d)); a zero divisor gives zeros.
//
//   channel  dir  handshake      fields
//   req      in   valid/ready    divisor[30:0]
//   rsp      out  valid/ready    magic[31:0] signed, shift[4:0]
//
// One word at a time: accept, two encoder passes, 32 restoring divide
// steps, then the move into the output register; the next word is taken
// only when the controller is back in idle. The divider loop of 32 steps
// sets the rate. A stalled result waits in the output register while the
// next word is taken and computed; only the final transfer waits for it.
// Reset clears the controller and the datapath step counter; no other state.
// ----------------------------------------------------------------------------
module division_magic_number
    import dmn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dmn_req_if.sink   req,
    dmn_rsp_if.source rsp
);

    dmn_cmd_t cmd;
    dmn_sts_t sts;

    dmn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dmn_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .divisor (req.divisor),
        .magic   (rsp.magic),
        .shift   (rsp.shift)
    );

endmodule

FILE: rtl/core/dmn_checker.sv
// ----------------------------------------------------------------------------
// dmn_checker: port-level checks
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module dmn_checker
    import dmn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [MagicW-1:0] rsp_magic,
    input logic [ShiftW-1:0] rsp_shift
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magic) && $stable(rsp_shift))
        else $error("result word changed while stalled");

    // one word at a time: no accept on the cycle after an accept
    a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken while busy");

    a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> ##1 !req_ready)
        else $error("input taken while busy");

    // a new result only comes out of a busy cycle
    a_rsp_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without work");

endmodule

bind division_magic_number dmn_checker u_dmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_magic (rsp.magic),
    .rsp_shift (rsp.shift)
);
